### rtl/mee_pkg.sv
package mee_pkg;

    localparam int QUEUE_DEPTH = 4;
    localparam int OUT_DEPTH   = 2;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 2;

    localparam logic [CFG_IDX_W-1:0] REG_TRACKING = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DECIMAL  = 1'd1;

    localparam logic [1:0] MODE_NONE  = 2'd0;
    localparam logic [1:0] MODE_PRESS = 2'd1;
    localparam logic [1:0] MODE_DRAG  = 2'd2;
    localparam logic [1:0] MODE_ANY   = 2'd3;

    localparam int COORD_W = 16;
    localparam int CODE_W  = 7;
    localparam int BCD_W   = 20;
    localparam int CBCD_W  = 12;

    localparam logic [CODE_W-1:0] BTN_WHEEL  = 7'd64;
    localparam logic [CODE_W-1:0] BTN_HWHEEL = 7'd66;
    localparam logic [CODE_W-1:0] BTN_MOTION = 7'd32;

    localparam logic [7:0] CH_ESC     = 8'h1B;
    localparam logic [7:0] CH_BRACKET = 8'h5B;
    localparam logic [7:0] CH_LT      = 8'h3C;
    localparam logic [7:0] CH_SEMI    = 8'h3B;
    localparam logic [7:0] CH_PRESS   = 8'h4D;
    localparam logic [7:0] CH_RELEASE = 8'h6D;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] LEG_OFFSET = 8'h20;
    localparam logic [COORD_W-1:0] LEG_MAX = 16'd223;

    typedef struct packed {
        logic               left_down;
        logic               middle_down;
        logic               right_down;
        logic               moved;
        logic               wheeled;
        logic               hwheeled;
        logic signed [15:0] wheel_delta;
        logic               shift_key;
        logic               alt_key;
        logic               ctrl_key;
        logic [14:0]        column;
        logic [14:0]        row;
    } t_event;

    typedef struct packed {
        logic [7:0] byte_first;
        logic [7:0] byte_second;
        logic       second_valid;
        logic       last_of_event;
    } t_result;

    typedef struct packed {
        logic [CODE_W-1:0]  code;
        logic               rel;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic               last;
    } t_report;

    typedef struct packed {
        t_report           rep;
        logic [CBCD_W-1:0] dc;
        logic [BCD_W-1:0]  dx;
        logic [BCD_W-1:0]  dy;
    } t_conv;

    // one shift-add-3 step of binary to BCD
    function automatic logic [BCD_W-1:0] dd_step(input logic [BCD_W-1:0] bcd, input logic din);
        logic [BCD_W-1:0] adj;
        adj = bcd;
        for (int k = 0; k < BCD_W / 4; k++) begin
            if (adj[4*k +: 4] > 4'd4) begin
                adj[4*k +: 4] = adj[4*k +: 4] + 4'd3;
            end
        end
        return {adj[BCD_W-2:0], din};
    endfunction

endpackage

### rtl/mee_fifo.sv
module mee_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_wdata,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_rdata,
    output logic             o_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wptr;
    logic [PTR_W-1:0] r_rptr;
    logic [CNT_W-1:0] r_cnt;
    logic             wr;
    logic             rd;

    assign o_full  = (r_cnt == CNT_W'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign wr      = i_push && !o_full;
    assign rd      = i_pop && !o_empty;
    assign o_rdata = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (wr) begin
                r_wptr <= (r_wptr == PTR_W'(DEPTH - 1)) ? '0 : r_wptr + 1'b1;
            end
            if (rd) begin
                r_rptr <= (r_rptr == PTR_W'(DEPTH - 1)) ? '0 : r_rptr + 1'b1;
            end
            if (wr && !rd) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (rd && !wr) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr) begin
            r_mem[r_wptr] <= i_wdata;
        end
    end

endmodule

### rtl/mee_front.sv
module mee_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  mee_pkg::t_event  i_event,
    output logic             o_full,
    input  logic [1:0]       i_tracking_mode,
    output logic             o_q_push,
    output mee_pkg::t_report o_q_data,
    input  logic             i_q_full
);

    localparam int M_LEFT   = 0;
    localparam int M_MIDDLE = 1;
    localparam int M_RIGHT  = 2;
    localparam int M_WHEEL  = 3;
    localparam int M_HWHEEL = 4;
    localparam int M_MOTION = 5;
    localparam int M_W      = 6;

    logic [2:0]                  r_prev;
    logic [2:0]                  r_cur;
    logic [M_W-1:0]              r_mask;
    logic [4:0]                  r_mods;
    logic [mee_pkg::COORD_W-1:0] r_x;
    logic [mee_pkg::COORD_W-1:0] r_y;
    logic                        r_wcode;
    logic                        r_hcode;
    logic [1:0]                  r_msel;

    logic [M_W-1:0]              n_mask;
    logic [M_W-1:0]              rem;
    logic [2:0]                  cur;
    logic [2:0]                  diff;
    logic                        wheel_en;
    logic                        hwheel_en;
    logic                        motion_en;
    logic                        accept;
    logic [mee_pkg::CODE_W-1:0]  mods7;
    logic [mee_pkg::CODE_W-1:0]  code;
    logic                        rel;

    assign cur  = {i_event.right_down, i_event.middle_down, i_event.left_down};
    assign diff = cur ^ r_prev;
    assign wheel_en  = i_event.wheeled && (i_tracking_mode != mee_pkg::MODE_NONE);
    assign hwheel_en = i_event.hwheeled && (i_tracking_mode != mee_pkg::MODE_NONE);
    assign motion_en = !(|diff) && !wheel_en && !hwheel_en && i_event.moved
        && ((i_tracking_mode == mee_pkg::MODE_ANY)
            || ((i_tracking_mode == mee_pkg::MODE_DRAG) && (cur != 3'b000)));
    assign n_mask = {motion_en, hwheel_en, wheel_en, diff};

    assign rem      = r_mask & (r_mask - 1'b1);
    assign o_q_push = (r_mask != '0) && !i_q_full;
    assign o_full   = (r_mask != '0) && !(o_q_push && (rem == '0));
    assign accept   = i_push && !o_full;
    assign mods7    = {2'b00, r_mods};

    always_comb begin
        code = mods7;
        rel  = 1'b0;
        if (r_mask[M_LEFT]) begin
            rel = !r_cur[0];
        end else if (r_mask[M_MIDDLE]) begin
            code = mods7 + 7'd1;
            rel  = !r_cur[1];
        end else if (r_mask[M_RIGHT]) begin
            code = mods7 + 7'd2;
            rel  = !r_cur[2];
        end else if (r_mask[M_WHEEL]) begin
            code = mods7 + mee_pkg::BTN_WHEEL + {6'd0, r_wcode};
        end else if (r_mask[M_HWHEEL]) begin
            code = mods7 + mee_pkg::BTN_HWHEEL + {6'd0, r_hcode};
        end else if (r_mask[M_MOTION]) begin
            code = mods7 + mee_pkg::BTN_MOTION + {5'd0, r_msel};
        end
    end

    always_comb begin
        o_q_data.code = code;
        o_q_data.rel  = rel;
        o_q_data.x    = r_x;
        o_q_data.y    = r_y;
        o_q_data.last = (rem == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev <= '0;
            r_mask <= '0;
        end else if (accept) begin
            r_prev <= cur;
            r_mask <= n_mask;
        end else if (o_q_push) begin
            r_mask <= rem;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cur   <= cur;
            r_mods  <= {i_event.ctrl_key, i_event.alt_key, i_event.shift_key, 2'b00};
            r_x     <= {1'b0, i_event.column} + 16'd1;
            r_y     <= {1'b0, i_event.row} + 16'd1;
            // wheel down when negated delta <= -120 (most negative value stays put)
            r_wcode <= !((i_event.wheel_delta >= 16'sd120)
                         || (i_event.wheel_delta == -16'sd32768));
            r_hcode <= !(i_event.wheel_delta <= -16'sd120);
            if (i_event.left_down) begin
                r_msel <= 2'd0;
            end else if (i_event.middle_down) begin
                r_msel <= 2'd1;
            end else if (i_event.right_down) begin
                r_msel <= 2'd2;
            end else begin
                r_msel <= 2'd3;
            end
        end
    end

endmodule

### rtl/mee_conv.sv
module mee_conv (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_decimal,
    input  mee_pkg::t_report i_q_data,
    input  logic             i_q_empty,
    output logic             o_q_pop,
    output logic             o_valid,
    output mee_pkg::t_conv   o_data,
    input  logic             i_take
);

    localparam int STEPS = mee_pkg::COORD_W;
    localparam int CNT_W = $clog2(STEPS);

    logic                        r_busy;
    logic                        r_rdy;
    logic [CNT_W-1:0]            r_cnt;
    mee_pkg::t_report            r_rep;
    logic [mee_pkg::COORD_W-1:0] r_bx;
    logic [mee_pkg::COORD_W-1:0] r_by;
    logic [mee_pkg::COORD_W-1:0] r_bc;
    logic [mee_pkg::BCD_W-1:0]   r_dx;
    logic [mee_pkg::BCD_W-1:0]   r_dy;
    logic [mee_pkg::BCD_W-1:0]   r_dc;
    logic                        start;

    assign start   = !r_busy && !r_rdy && !i_q_empty;
    assign o_q_pop = start;
    assign o_valid = r_rdy;

    always_comb begin
        o_data.rep = r_rep;
        o_data.dc  = r_dc[mee_pkg::CBCD_W-1:0];
        o_data.dx  = r_dx;
        o_data.dy  = r_dy;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_rdy  <= 1'b0;
        end else if (start) begin
            r_busy <= i_decimal;
            r_rdy  <= !i_decimal;
        end else if (r_busy && (r_cnt == CNT_W'(STEPS - 1))) begin
            r_busy <= 1'b0;
            r_rdy  <= 1'b1;
        end else if (i_take) begin
            r_rdy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (start) begin
            r_rep <= i_q_data;
            r_bx  <= i_q_data.x;
            r_by  <= i_q_data.y;
            r_bc  <= {{(mee_pkg::COORD_W - mee_pkg::CODE_W){1'b0}}, i_q_data.code};
            r_dx  <= '0;
            r_dy  <= '0;
            r_dc  <= '0;
            r_cnt <= '0;
        end else if (r_busy) begin
            r_dx  <= mee_pkg::dd_step(r_dx, r_bx[mee_pkg::COORD_W-1]);
            r_dy  <= mee_pkg::dd_step(r_dy, r_by[mee_pkg::COORD_W-1]);
            r_dc  <= mee_pkg::dd_step(r_dc, r_bc[mee_pkg::COORD_W-1]);
            r_bx  <= {r_bx[mee_pkg::COORD_W-2:0], 1'b0};
            r_by  <= {r_by[mee_pkg::COORD_W-2:0], 1'b0};
            r_bc  <= {r_bc[mee_pkg::COORD_W-2:0], 1'b0};
            r_cnt <= r_cnt + 1'b1;
        end
    end

endmodule

### rtl/mee_emit.sv
module mee_emit (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_decimal,
    input  logic             i_valid,
    input  mee_pkg::t_conv   i_data,
    output logic             o_take,
    output logic             o_out_push,
    output mee_pkg::t_result o_out_data,
    input  logic             i_out_full
);

    // byte slots of one report
    localparam logic [4:0] SLOT_ESC     = 5'd0;
    localparam logic [4:0] SLOT_BRACKET = 5'd1;
    localparam logic [4:0] SLOT_INTRO   = 5'd2;
    localparam logic [4:0] SLOT_CODE    = 5'd3;
    localparam logic [4:0] SLOT_SEP1    = 5'd6;
    localparam logic [4:0] SLOT_X       = 5'd7;
    localparam logic [4:0] SLOT_SEP2    = 5'd12;
    localparam logic [4:0] SLOT_Y       = 5'd13;
    localparam logic [4:0] SLOT_FIN     = 5'd18;
    localparam logic [4:0] SLOT_LEG_CB  = 5'd3;
    localparam logic [4:0] SLOT_LEG_CX  = 5'd4;
    localparam logic [4:0] SLOT_LEG_CY  = 5'd5;

    logic                        r_active;
    logic [4:0]                  r_pos;
    logic [4:0]                  r_cs;
    logic [4:0]                  r_xs;
    logic [4:0]                  r_ys;
    logic [mee_pkg::CBCD_W-1:0]  r_dc;
    logic [mee_pkg::BCD_W-1:0]   r_dx;
    logic [mee_pkg::BCD_W-1:0]   r_dy;
    logic                        r_rel;
    logic                        r_last;
    logic [7:0]                  r_cb;
    logic [7:0]                  r_cx;
    logic [7:0]                  r_cy;
    logic                        r_hold_v;
    logic [7:0]                  r_hold_b;

    logic [7:0]                  cur_byte;
    logic                        fin;
    logic [4:0]                  n_pos;
    logic                        byte_last;
    logic                        need_push;
    logic                        adv;
    logic [mee_pkg::CODE_W-1:0]  lcode;

    // slot of the most significant nonzero digit, digits at base .. base+4
    function automatic logic [4:0] first_slot(input logic [mee_pkg::BCD_W-1:0] d,
                                              input logic [4:0] base);
        logic [4:0] s;
        if (d[19:16] != 4'd0) begin
            s = base;
        end else if (d[15:12] != 4'd0) begin
            s = base + 5'd1;
        end else if (d[11:8] != 4'd0) begin
            s = base + 5'd2;
        end else if (d[7:4] != 4'd0) begin
            s = base + 5'd3;
        end else begin
            s = base + 5'd4;
        end
        return s;
    endfunction

    function automatic logic [7:0] leg_coord(input logic [mee_pkg::COORD_W-1:0] v);
        logic [7:0] b;
        if ((v == '0) || (v > mee_pkg::LEG_MAX)) begin
            b = 8'h00;
        end else begin
            b = v[7:0] + mee_pkg::LEG_OFFSET;
        end
        return b;
    endfunction

    function automatic logic [7:0] digit(input logic [3:0] d);
        return mee_pkg::CH_ZERO | {4'h0, d};
    endfunction

    assign o_take = i_valid && !r_active;
    assign lcode  = i_data.rep.rel ? {2'b00, i_data.rep.code[4:2], 2'b11} : i_data.rep.code;

    always_comb begin
        cur_byte = mee_pkg::CH_ESC;
        if (i_decimal) begin
            case (r_pos)
                SLOT_ESC:         cur_byte = mee_pkg::CH_ESC;
                SLOT_BRACKET:     cur_byte = mee_pkg::CH_BRACKET;
                SLOT_INTRO:       cur_byte = mee_pkg::CH_LT;
                SLOT_CODE:        cur_byte = digit(r_dc[11:8]);
                SLOT_CODE + 5'd1: cur_byte = digit(r_dc[7:4]);
                SLOT_CODE + 5'd2: cur_byte = digit(r_dc[3:0]);
                SLOT_SEP1:        cur_byte = mee_pkg::CH_SEMI;
                SLOT_X:           cur_byte = digit(r_dx[19:16]);
                SLOT_X + 5'd1:    cur_byte = digit(r_dx[15:12]);
                SLOT_X + 5'd2:    cur_byte = digit(r_dx[11:8]);
                SLOT_X + 5'd3:    cur_byte = digit(r_dx[7:4]);
                SLOT_X + 5'd4:    cur_byte = digit(r_dx[3:0]);
                SLOT_SEP2:        cur_byte = mee_pkg::CH_SEMI;
                SLOT_Y:           cur_byte = digit(r_dy[19:16]);
                SLOT_Y + 5'd1:    cur_byte = digit(r_dy[15:12]);
                SLOT_Y + 5'd2:    cur_byte = digit(r_dy[11:8]);
                SLOT_Y + 5'd3:    cur_byte = digit(r_dy[7:4]);
                SLOT_Y + 5'd4:    cur_byte = digit(r_dy[3:0]);
                SLOT_FIN:         cur_byte = r_rel ? mee_pkg::CH_RELEASE : mee_pkg::CH_PRESS;
                default:          cur_byte = mee_pkg::CH_ESC;
            endcase
        end else begin
            case (r_pos)
                SLOT_ESC:     cur_byte = mee_pkg::CH_ESC;
                SLOT_BRACKET: cur_byte = mee_pkg::CH_BRACKET;
                SLOT_INTRO:   cur_byte = mee_pkg::CH_PRESS;
                SLOT_LEG_CB:  cur_byte = r_cb;
                SLOT_LEG_CX:  cur_byte = r_cx;
                SLOT_LEG_CY:  cur_byte = r_cy;
                default:      cur_byte = mee_pkg::CH_ESC;
            endcase
        end
    end

    always_comb begin
        fin   = i_decimal ? (r_pos == SLOT_FIN) : (r_pos == SLOT_LEG_CY);
        n_pos = r_pos + 5'd1;
        if (i_decimal) begin
            case (r_pos)
                SLOT_INTRO: n_pos = r_cs;
                SLOT_SEP1:  n_pos = r_xs;
                SLOT_SEP2:  n_pos = r_ys;
                default:    n_pos = r_pos + 5'd1;
            endcase
        end
    end

    assign byte_last  = fin && r_last;
    assign need_push  = r_hold_v || byte_last;
    assign adv        = r_active && (!need_push || !i_out_full);
    assign o_out_push = adv && need_push;

    always_comb begin
        if (r_hold_v) begin
            o_out_data.byte_first   = r_hold_b;
            o_out_data.byte_second  = cur_byte;
            o_out_data.second_valid = 1'b1;
        end else begin
            o_out_data.byte_first   = cur_byte;
            o_out_data.byte_second  = 8'h00;
            o_out_data.second_valid = 1'b0;
        end
        o_out_data.last_of_event = byte_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_hold_v <= 1'b0;
        end else begin
            if (o_take) begin
                r_active <= 1'b1;
            end else if (adv && fin) begin
                r_active <= 1'b0;
            end
            if (adv) begin
                r_hold_v <= !r_hold_v && !byte_last;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_hold_b <= cur_byte;
        end
        if (o_take) begin
            r_pos  <= SLOT_ESC;
        end else if (adv) begin
            r_pos  <= n_pos;
        end
        if (o_take) begin
            r_cs   <= first_slot({8'h00, i_data.dc}, SLOT_CODE - 5'd2);
            r_xs   <= first_slot(i_data.dx, SLOT_X);
            r_ys   <= first_slot(i_data.dy, SLOT_Y);
            r_dc   <= i_data.dc;
            r_dx   <= i_data.dx;
            r_dy   <= i_data.dy;
            r_rel  <= i_data.rep.rel;
            r_last <= i_data.rep.last;
            r_cb   <= mee_pkg::LEG_OFFSET + {1'b0, lcode};
            r_cx   <= leg_coord(i_data.rep.x);
            r_cy   <= leg_coord(i_data.rep.y);
        end
    end

endmodule

### rtl/mouse_event_escape_encoder.sv
// channel   direction  handshake             payload
// ------------------------------------------------------------------
// event     in         push / full           i_event  (t_event)
// result    out        pop / empty           o_result (t_result)
// config    in         i_cfg_we, i_cfg_idx   i_cfg_data
//
// Front accepts an event once its last report enters the queue, one report per cycle while the queue has room.
// SGR report: a binary-to-BCD pass, overlapped with the previous report's bytes.
// Byte serializer loads each report, then moves one byte per cycle while the result queue
// has room; bytes pair into results.
// Reset is synchronous, active low; it clears button history and all queues.
// A full result queue stalls the serializer, then the converter, then the front.
module mouse_event_escape_encoder #(
    parameter int QUEUE_DEPTH = mee_pkg::QUEUE_DEPTH,
    parameter int OUT_DEPTH   = mee_pkg::OUT_DEPTH
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           push,
    output logic                           full,
    input  mee_pkg::t_event                i_event,
    output logic                           empty,
    input  logic                           pop,
    output mee_pkg::t_result               o_result,
    input  logic                           i_cfg_we,
    input  logic [mee_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [mee_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    logic [1:0]       r_tracking_mode;
    logic             r_decimal;

    logic             q_push;
    logic             q_full;
    logic             q_pop;
    logic             q_empty;
    mee_pkg::t_report q_wdata;
    mee_pkg::t_report q_rdata;
    logic             conv_valid;
    logic             conv_take;
    mee_pkg::t_conv   conv_data;
    logic             out_push;
    logic             out_full;
    mee_pkg::t_result out_wdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tracking_mode <= mee_pkg::MODE_NONE;
            r_decimal       <= 1'b1;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                mee_pkg::REG_TRACKING: r_tracking_mode <= i_cfg_data[1:0];
                mee_pkg::REG_DECIMAL:  r_decimal       <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    mee_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_push          (push),
        .i_event         (i_event),
        .o_full          (full),
        .i_tracking_mode (r_tracking_mode),
        .o_q_push        (q_push),
        .o_q_data        (q_wdata),
        .i_q_full        (q_full)
    );

    mee_fifo #(
        .WIDTH ($bits(mee_pkg::t_report)),
        .DEPTH (QUEUE_DEPTH)
    ) u_report_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_wdata (q_wdata),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_rdata (q_rdata),
        .o_empty (q_empty)
    );

    mee_conv u_conv (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_decimal (r_decimal),
        .i_q_data  (q_rdata),
        .i_q_empty (q_empty),
        .o_q_pop   (q_pop),
        .o_valid   (conv_valid),
        .o_data    (conv_data),
        .i_take    (conv_take)
    );

    mee_emit u_emit (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_decimal  (r_decimal),
        .i_valid    (conv_valid),
        .i_data     (conv_data),
        .o_take     (conv_take),
        .o_out_push (out_push),
        .o_out_data (out_wdata),
        .i_out_full (out_full)
    );

    mee_fifo #(
        .WIDTH ($bits(mee_pkg::t_result)),
        .DEPTH (OUT_DEPTH)
    ) u_result_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (out_push),
        .i_wdata (out_wdata),
        .o_full  (out_full),
        .i_pop   (pop),
        .o_rdata (o_result),
        .o_empty (empty)
    );

endmodule

### verif/mouse_event_escape_encoder_tb.sv
`timescale 1ns / 100ps

module mouse_event_escape_encoder_tb;
    import mee_pkg::*;

    localparam int DRAIN_CYCLES  = 200;
    localparam int HOLD_CYCLES   = 300;
    localparam int ITEMS_PER_CFG = 50;
    localparam int PRESSURE_ITEMS = 30;

    typedef struct {
        t_event     ev;
        logic [1:0] mode;
        logic       sgr;
        int         n_typed;
        t_result    typed [3];
    } t_row;

    logic                  i_clk      = 1'b0;
    logic                  i_rst_n    = 1'b0;
    logic                  push       = 1'b0;
    logic                  full;
    t_event                i_event    = '0;
    logic                  empty;
    logic                  pop        = 1'b0;
    t_result               o_result;
    logic                  i_cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx  = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    // shadow of the block's registers and button history
    logic [1:0] trk_mode = MODE_NONE;
    logic       use_sgr  = 1'b1;
    logic [2:0] btn_prev = '0;

    byte unsigned report_bytes[$];
    t_result      chunk_q[$];
    t_row         rows[$];

    int unsigned errors       = 0;
    int unsigned n_events     = 0;
    int unsigned n_chunks     = 0;
    int unsigned n_full_waits = 0;
    bit          quiet        = 1'b0;
    bit          hold_req     = 1'b0;

    logic [1:0] mode_plan [4] = '{MODE_ANY, MODE_DRAG, MODE_PRESS, MODE_NONE};

    mouse_event_escape_encoder uut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .push      (push),
        .full      (full),
        .i_event   (i_event),
        .empty     (empty),
        .pop       (pop),
        .o_result  (o_result),
        .i_cfg_we  (i_cfg_we),
        .i_cfg_idx (i_cfg_idx),
        .i_cfg_data(i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic void put_dec(int unsigned v);
        string s;
        s = $sformatf("%0d", v);
        for (int k = 0; k < s.len(); k++) begin
            report_bytes.push_back(s[k]);
        end
    endfunction

    function automatic logic [7:0] leg_coord(int unsigned v);
        return (v < 1 || v > LEG_MAX) ? 8'd0 : 8'(v + LEG_OFFSET);
    endfunction

    function automatic void add_report(logic [7:0] code, int unsigned x, int unsigned y, bit rel);
        if (use_sgr) begin
            report_bytes.push_back(CH_ESC);
            report_bytes.push_back(CH_BRACKET);
            report_bytes.push_back(CH_LT);
            put_dec(32'(code));
            report_bytes.push_back(CH_SEMI);
            put_dec(x);
            report_bytes.push_back(CH_SEMI);
            put_dec(y);
            report_bytes.push_back(rel ? CH_RELEASE : CH_PRESS);
        end else begin
            if (rel) begin
                code = (code & 8'h1C) | 8'h03;
            end
            report_bytes.push_back(CH_ESC);
            report_bytes.push_back(CH_BRACKET);
            report_bytes.push_back(CH_PRESS);
            report_bytes.push_back(8'(code + LEG_OFFSET));
            report_bytes.push_back(leg_coord(x));
            report_bytes.push_back(leg_coord(y));
        end
    endfunction

    // builds the report byte stream of one event and advances button history
    function automatic void encode_mouse_event(t_event ev);
        logic [2:0]  cur;
        logic [2:0]  chg;
        logic [7:0]  mods;
        logic [7:0]  code;
        int unsigned x;
        int unsigned y;
        int          neg;
        bit          any;
        cur = {ev.right_down, ev.middle_down, ev.left_down};
        chg = cur ^ btn_prev;
        btn_prev = cur;
        mods = {3'b000, ev.ctrl_key, ev.alt_key, ev.shift_key, 2'b00};
        x = 32'(ev.column) + 1;
        y = 32'(ev.row) + 1;
        any = (chg != 3'b000);
        report_bytes.delete();
        for (int b = 0; b < 3; b++) begin
            if (chg[b]) begin
                add_report(mods + 8'(b), x, y, !cur[b]);
            end
        end
        if (ev.wheeled && trk_mode != MODE_NONE) begin
            // negation wraps at 16 bits, so the most negative delta stays negative
            neg = -int'($signed(ev.wheel_delta));
            if (neg == 32768) begin
                neg = -32768;
            end
            code = (neg <= -120) ? 8'(BTN_WHEEL) : 8'(BTN_WHEEL) + 8'd1;
            add_report(mods + code, x, y, 1'b0);
            any = 1'b1;
        end
        if (ev.hwheeled && trk_mode != MODE_NONE) begin
            code = ($signed(ev.wheel_delta) <= -120) ? 8'(BTN_HWHEEL) : 8'(BTN_HWHEEL) + 8'd1;
            add_report(mods + code, x, y, 1'b0);
            any = 1'b1;
        end
        if (!any && ev.moved &&
            (trk_mode == MODE_ANY || (trk_mode == MODE_DRAG && cur != 3'b000))) begin
            code = mods | 8'(BTN_MOTION);
            if (cur[0]) begin
                code = code;
            end else if (cur[1]) begin
                code = code + 8'd1;
            end else if (cur[2]) begin
                code = code + 8'd2;
            end else begin
                code = code + 8'd3;
            end
            add_report(code, x, y, 1'b0);
        end
    endfunction

    function automatic t_event ev_of(bit l, bit m, bit r, bit mv, bit wh, bit hw,
                                     logic signed [15:0] delta, bit s, bit a, bit c,
                                     logic [14:0] col, logic [14:0] rw);
        t_event ev;
        ev.left_down   = l;
        ev.middle_down = m;
        ev.right_down  = r;
        ev.moved       = mv;
        ev.wheeled     = wh;
        ev.hwheeled    = hw;
        ev.wheel_delta = delta;
        ev.shift_key   = s;
        ev.alt_key     = a;
        ev.ctrl_key    = c;
        ev.column      = col;
        ev.row         = rw;
        return ev;
    endfunction

    function automatic void add_row(t_event ev, logic [1:0] mode, logic sgr, int n,
                                    t_result r0 = '0, t_result r1 = '0, t_result r2 = '0);
        t_row r;
        r.ev       = ev;
        r.mode     = mode;
        r.sgr      = sgr;
        r.n_typed  = n;
        r.typed[0] = r0;
        r.typed[1] = r1;
        r.typed[2] = r2;
        rows.push_back(r);
    endfunction

    function automatic logic [14:0] rand_coord();
        int p;
        p = $urandom_range(0, 19);
        if (p < 11) begin
            return 15'($urandom_range(0, 230));
        end
        if (p < 16) begin
            return 15'($urandom_range(219, 224));
        end
        return 15'($urandom_range(0, 32766));
    endfunction

    function automatic t_event rand_event();
        t_event ev;
        int     p;
        int     k;
        ev.left_down   = 1'($urandom_range(0, 1));
        ev.middle_down = 1'($urandom_range(0, 1));
        ev.right_down  = 1'($urandom_range(0, 1));
        ev.moved       = ($urandom_range(0, 9) < 7);
        ev.wheeled     = ($urandom_range(0, 4) == 0);
        ev.hwheeled    = ($urandom_range(0, 5) == 0);
        p = $urandom_range(0, 9);
        if (p < 4) begin
            k = int'($urandom_range(0, 10)) - 5;
            ev.wheel_delta = 16'(120 * k);
        end else if (p < 7) begin
            case ($urandom_range(0, 7))
                0: ev.wheel_delta = 16'(119);
                1: ev.wheel_delta = 16'(120);
                2: ev.wheel_delta = 16'(-119);
                3: ev.wheel_delta = 16'(-120);
                4: ev.wheel_delta = 16'(-121);
                5: ev.wheel_delta = 16'(0);
                6: ev.wheel_delta = 16'(32767);
                default: ev.wheel_delta = 16'(-32768);
            endcase
        end else begin
            ev.wheel_delta = 16'($urandom);
        end
        ev.shift_key = 1'($urandom_range(0, 1));
        ev.alt_key   = 1'($urandom_range(0, 1));
        ev.ctrl_key  = 1'($urandom_range(0, 1));
        ev.column    = rand_coord();
        ev.row       = rand_coord();
        return ev;
    endfunction

    // mostly short gaps, a few long ones
    function automatic int pick_gap();
        int p;
        p = $urandom_range(0, 99);
        if (p < 50) begin
            return 0;
        end
        if (p < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    task automatic send_event(t_row r);
        push    <= 1'b1;
        i_event <= r.ev;
        @(posedge i_clk);
        while (full) begin
            n_full_waits++;
            @(posedge i_clk);
        end
        n_events++;
        encode_mouse_event(r.ev);
        if (r.n_typed < 0) begin
            for (int k = 0; k < report_bytes.size(); k += 2) begin
                t_result c;
                c.byte_first    = report_bytes[k];
                c.second_valid  = (k + 1 < report_bytes.size());
                c.byte_second   = c.second_valid ? report_bytes[k + 1] : 8'd0;
                c.last_of_event = (k + 2 >= report_bytes.size());
                chunk_q.push_back(c);
            end
        end else begin
            for (int k = 0; k < r.n_typed; k++) begin
                chunk_q.push_back(r.typed[k]);
            end
        end
    endtask

    task automatic idle_sender();
        int n;
        n = quiet ? 0 : pick_gap();
        if (n > 0) begin
            push <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    // zero-result events may still be in flight once the queue drains
    task automatic wait_idle();
        push <= 1'b0;
        while (chunk_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_config(logic [1:0] mode, logic sgr);
        wait_idle();
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= REG_TRACKING;
        i_cfg_data <= mode;
        @(posedge i_clk);
        i_cfg_idx  <= REG_DECIMAL;
        i_cfg_data <= {1'b0, sgr};
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        trk_mode = mode;
        use_sgr  = sgr;
    endtask

    initial begin : result_side
        int      stall;
        t_result want;
        stall = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && pop && !empty) begin
                n_chunks++;
                if (chunk_q.size() == 0) begin
                    $error("unexpected result transfer: %p", o_result);
                    errors++;
                end else begin
                    want = chunk_q.pop_front();
                    if (o_result.byte_first !== want.byte_first) begin
                        $error("byte_first: expected %h, got %h",
                               want.byte_first, o_result.byte_first);
                        errors++;
                    end
                    if (o_result.byte_second !== want.byte_second) begin
                        $error("byte_second: expected %h, got %h",
                               want.byte_second, o_result.byte_second);
                        errors++;
                    end
                    if (o_result.second_valid !== want.second_valid) begin
                        $error("second_valid: expected %b, got %b",
                               want.second_valid, o_result.second_valid);
                        errors++;
                    end
                    if (o_result.last_of_event !== want.last_of_event) begin
                        $error("last_of_event: expected %b, got %b",
                               want.last_of_event, o_result.last_of_event);
                        errors++;
                    end
                end
                if (!quiet && stall == 0) begin
                    stall = pick_gap();
                end
            end
            if (hold_req) begin
                hold_req = 1'b0;
                stall = HOLD_CYCLES;
            end
            if (stall > 0) begin
                pop <= 1'b0;
                stall--;
            end else begin
                pop <= 1'b1;
            end
        end
    end

    initial begin : stimulus
        t_row r;

        add_row(ev_of(0,0,0, 1,0,0, 0, 0,0,0, 5,5), MODE_NONE, 1'b1, 0);
        add_row(ev_of(1,0,0, 0,0,0, 0, 0,0,0, 0,0), MODE_NONE, 1'b1, -1);
        add_row(ev_of(0,0,0, 1,0,0, 0, 1,1,1, 32766,32766), MODE_NONE, 1'b1, -1);
        add_row(ev_of(1,0,0, 0,0,0, 0, 0,0,0, 0,0), MODE_PRESS, 1'b0, 3,
                '{CH_ESC, CH_BRACKET, 1'b1, 1'b0}, '{CH_PRESS, 8'h20, 1'b1, 1'b0},
                '{8'h21, 8'h21, 1'b1, 1'b1});
        // legacy release with shift; column 223 fits, row 224 is out of range and sent as zero
        add_row(ev_of(0,0,0, 0,0,0, 0, 1,0,0, 222,223), MODE_PRESS, 1'b0, 3,
                '{CH_ESC, CH_BRACKET, 1'b1, 1'b0}, '{CH_PRESS, 8'h27, 1'b1, 1'b0},
                '{8'hFF, 8'h00, 1'b1, 1'b1});
        add_row(ev_of(0,0,0, 0,1,0, 120, 0,0,0, 0,0), MODE_PRESS, 1'b0, 3,
                '{CH_ESC, CH_BRACKET, 1'b1, 1'b0}, '{CH_PRESS, 8'h60, 1'b1, 1'b0},
                '{8'h21, 8'h21, 1'b1, 1'b1});
        add_row(ev_of(0,0,0, 0,1,0, 119, 0,0,0, 0,0), MODE_PRESS, 1'b0, 3,
                '{CH_ESC, CH_BRACKET, 1'b1, 1'b0}, '{CH_PRESS, 8'h61, 1'b1, 1'b0},
                '{8'h21, 8'h21, 1'b1, 1'b1});
        add_row(ev_of(0,0,0, 0,1,0, -32768, 0,0,0, 100,7), MODE_PRESS, 1'b0, -1);
        add_row(ev_of(0,0,0, 0,1,0, 32767, 0,0,0, 100,7), MODE_PRESS, 1'b0, -1);
        add_row(ev_of(0,0,0, 0,0,1, -120, 0,0,0, 100,7), MODE_PRESS, 1'b0, -1);
        add_row(ev_of(0,0,0, 0,0,1, -119, 0,0,0, 100,7), MODE_PRESS, 1'b0, -1);
        add_row(ev_of(0,0,0, 0,0,1, 32767, 0,0,0, 100,7), MODE_PRESS, 1'b0, -1);
        add_row(ev_of(0,1,1, 1,1,1, 0, 0,1,0, 300,40), MODE_PRESS, 1'b1, -1);
        add_row(ev_of(0,1,1, 1,1,0, 240, 0,0,0, 1,1), MODE_NONE, 1'b1, 0);
        add_row(ev_of(0,1,1, 1,0,0, 0, 1,0,1, 10,20), MODE_DRAG, 1'b1, -1);
        add_row(ev_of(0,0,0, 0,0,0, 0, 0,0,0, 10,20), MODE_DRAG, 1'b1, -1);
        add_row(ev_of(0,0,0, 1,0,0, 0, 1,1,1, 0,0), MODE_DRAG, 1'b1, 0);
        add_row(ev_of(0,0,0, 1,0,0, 0, 1,1,1, 0,0), MODE_ANY, 1'b1, -1);
        add_row(ev_of(0,0,1, 1,0,0, 0, 0,0,0, 3,4), MODE_ANY, 1'b1, -1);
        add_row(ev_of(0,0,1, 1,0,0, 0, 0,0,0, 3,4), MODE_ANY, 1'b1, -1);
        add_row(ev_of(1,1,1, 1,0,0, 0, 0,0,1, 223,0), MODE_ANY, 1'b0, -1);
        add_row(ev_of(0,0,0, 1,0,0, 0, 1,1,1, 221,222), MODE_ANY, 1'b0, -1);
        add_row(ev_of(1,1,1, 1,1,1, -32768, 1,1,1, 32766,32766), MODE_ANY, 1'b1, -1);
        add_row(ev_of(1,1,1, 1,0,0, 0, 0,0,0, 0,0), MODE_ANY, 1'b0, -1);
        add_row(ev_of(1,1,1, 1,0,0, 0, 0,0,0, 0,0), MODE_ANY, 1'b0, -1);

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (rows[k]) begin
            if (rows[k].mode != trk_mode || rows[k].sgr != use_sgr) begin
                set_config(rows[k].mode, rows[k].sgr);
            end
            send_event(rows[k]);
            idle_sender();
        end

        r.n_typed = -1;
        for (int p = 0; p < 8; p++) begin
            set_config(mode_plan[p % 4], (p >= 4));
            quiet = (p == 5);
            for (int k = 0; k < ITEMS_PER_CFG; k++) begin
                r.ev = rand_event();
                send_event(r);
                idle_sender();
            end
        end

        // receiver holds off while events keep coming, so the block backs up
        set_config(MODE_ANY, 1'b1);
        quiet = 1'b1;
        hold_req = 1'b1;
        for (int k = 0; k < PRESSURE_ITEMS; k++) begin
            r.ev = rand_event();
            send_event(r);
        end
        quiet = 1'b0;

        wait_idle();
        $display("Ran %0d mouse events over all tracking modes in SGR and legacy form;",
                 n_events);
        $display("checked %0d result transfers, input held off on %0d cycles.",
                 n_chunks, n_full_waits);
        if (errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    initial begin : watchdog
        #40ms;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
